// ----- rtl/base64_stream_decoder_top_defines.svh -----
// ============================================================================
// Base64 stream decoder assertion macros
// Shared concurrent assertion forms used by the decoder RTL.
// ============================================================================
`ifndef BASE64_STREAM_DECODER_TOP_DEFINES_SVH
`define BASE64_STREAM_DECODER_TOP_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define B64D_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define B64D_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/b64d_pkg.sv -----
// ============================================================================
// b64d_pkg
// Types and constants shared by the base64 stream decoder modules.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package b64d_pkg;

    // Depth of the command queue between front and back.
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    // One input word.
    typedef struct packed {
        logic [7:0] in_char;
        logic       in_last;
    } t_in;

    // One output word.
    typedef struct packed {
        logic [7:0] out_byte;
        logic       has_data;
        logic       is_last;
    } t_out;

    // One queued command: one to three output words, bytes left-justified.
    typedef struct packed {
        logic [23:0] data;
        logic [1:0]  nres;
        logic        bare;
        logic        last;
    } t_cmd;

    // Queue status seen by the front and the back.
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

`default_nettype wire

// ----- rtl/b64d_front.sv -----
// ============================================================================
// b64d_front
// Accepts characters, maps them to sextets and forms byte commands.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module b64d_front
    import b64d_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_valid,
    input  wire t_in     i_data,
    input  wire t_q_stat i_q_stat,
    output logic         o_stall,
    output logic         o_push,
    output t_cmd         o_cmd
);

    // Bit 6 set means the character is outside the alphabet.
    function automatic logic [6:0] sextet_of(input logic [7:0] c);
        logic [6:0] r;
        begin
            r = 7'h40;
            if (c >= 8'h41 && c <= 8'h5A) begin
                r = {1'b0, 6'(c - 8'h41)};
            end else if (c >= 8'h61 && c <= 8'h7A) begin
                r = {1'b0, 6'(c - 8'h61 + 8'd26)};
            end else if (c >= 8'h30 && c <= 8'h39) begin
                r = {1'b0, 6'(c - 8'h30 + 8'd52)};
            end else if (c == 8'h2B) begin
                r = 7'd62;
            end else if (c == 8'h2F) begin
                r = 7'd63;
            end
            sextet_of = r;
        end
    endfunction

    logic [17:0] r_hold, n_hold;
    logic [1:0]  r_count, n_count;
    logic        r_stopped, n_stopped;
    logic [6:0]  sx;
    logic        do_flush;
    logic        accept;

    assign o_stall = i_q_stat.full;
    assign accept  = i_valid && !o_stall;

    always_comb begin
        sx        = sextet_of(i_data.in_char);
        n_hold    = r_hold;
        n_count   = r_count;
        n_stopped = r_stopped;
        do_flush  = 1'b0;
        o_cmd     = '0;

        if (!r_stopped) begin
            if (!sx[6]) begin
                if (r_count == 2'd3) begin
                    o_cmd.data = {r_hold, sx[5:0]};
                    o_cmd.nres = 2'd3;
                    n_hold     = '0;
                    n_count    = 2'd0;
                end else begin
                    n_hold  = {r_hold[11:0], sx[5:0]};
                    n_count = r_count + 2'd1;
                end
                do_flush = i_data.in_last;
            end else begin
                do_flush  = 1'b1;
                n_stopped = 1'b1;
            end
        end

        // A partial group gives one byte fewer than it has sextets.
        if (do_flush) begin
            case (n_count)
                2'd2: begin
                    o_cmd.data = {n_hold[11:4], 16'd0};
                    o_cmd.nres = 2'd1;
                end
                2'd3: begin
                    o_cmd.data = {n_hold[17:10], n_hold[9:2], 8'd0};
                    o_cmd.nres = 2'd2;
                end
                default: begin
                end
            endcase
            n_hold  = '0;
            n_count = 2'd0;
        end

        if (i_data.in_last) begin
            if (o_cmd.nres == 2'd0) begin
                o_cmd.bare = 1'b1;
                o_cmd.nres = 2'd1;
            end
            o_cmd.last = 1'b1;
            n_hold     = '0;
            n_count    = 2'd0;
            n_stopped  = 1'b0;
        end

        o_push = accept && (o_cmd.nres != 2'd0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold    <= '0;
            r_count   <= 2'd0;
            r_stopped <= 1'b0;
        end else if (accept) begin
            r_hold    <= n_hold;
            r_count   <= n_count;
            r_stopped <= n_stopped;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/b64d_queue.sv -----
// ============================================================================
// b64d_queue
// Short command queue that decouples the front from the back.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

`include "base64_stream_decoder_top_defines.svh"

module b64d_queue
    import b64d_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cmd i_cmd,
    input  wire logic i_pop,
    output t_cmd      o_cmd,
    output t_q_stat   o_stat
);

    t_cmd          r_mem [Q_DEPTH];
    logic [Q_AW:0] r_wptr;
    logic [Q_AW:0] r_rptr;
    logic [Q_AW:0] fill;

    assign fill         = r_wptr - r_rptr;
    assign o_stat.full  = (fill == (Q_AW + 1)'(Q_DEPTH));
    assign o_stat.empty = (r_wptr == r_rptr);
    assign o_cmd        = r_mem[r_rptr[Q_AW-1:0]];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr[Q_AW-1:0]] <= i_cmd;
        end
    end

    `B64D_ASSERT_NOW(a_no_push_full, i_push, !o_stat.full, "push into full queue")
    `B64D_ASSERT_NOW(a_no_pop_empty, i_pop, !o_stat.empty, "pop from empty queue")
    `B64D_ASSERT_NEXT(a_fill_up, i_push && !i_pop, fill == $past(fill) + 1'b1, "fill lost a push")

endmodule

`default_nettype wire

// ----- rtl/b64d_back.sv -----
// ============================================================================
// b64d_back
// Takes commands from the queue and emits them one output word per cycle while the output is not stalled.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module b64d_back
    import b64d_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire t_cmd    i_cmd,
    input  wire t_q_stat i_q_stat,
    output logic         o_pop,
    output logic         o_valid,
    output t_out         o_data,
    input  wire logic    i_stall
);

    logic r_busy;
    t_cmd r_cur;
    logic take;
    logic finish;

    assign o_valid         = r_busy;
    assign o_data.out_byte = r_cur.data[23:16];
    assign o_data.has_data = !r_cur.bare;
    assign o_data.is_last  = r_cur.last && (r_cur.nres == 2'd1);

    assign take   = r_busy && !i_stall;
    assign finish = take && (r_cur.nres == 2'd1);
    assign o_pop  = (!r_busy || finish) && !i_q_stat.empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (o_pop) begin
            r_busy <= 1'b1;
        end else if (finish) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cur <= i_cmd;
        end else if (take) begin
            r_cur.data <= {r_cur.data[15:0], 8'd0};
            r_cur.nres <= r_cur.nres - 2'd1;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/base64_stream_decoder_top.sv -----
// ============================================================================
// base64_stream_decoder_top
// Streaming base64 decoder: one character per word in, one byte per word out.
// ============================================================================
// The block takes one ASCII character per input word, with a flag on the final
// character of a message, and returns decoded bytes one per output word. Every
// fourth alphabet character yields three bytes; the first '=' or foreign
// character stops decoding until the message end, flushing any partial group.
// The final output word of a message has is_last set, and a message that ends
// with no pending byte gives one word with has_data clear. An input word is
// taken every cycle while the four-entry command queue has room; the output
// port sends at most one word per cycle while not stalled, so a full group of
// four characters fills three output words and plain text streams at one
// character per cycle. With the queue empty and the back idle, the first byte
// of an accepted character goes into the command queue at the accepting edge,
// then into the back's current-command register, which drives the output. The
// input stalls only when the queue is full, which follows from output stalling.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module base64_stream_decoder_top
    import b64d_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    // Input channel: one encoded character per word.
    input  wire logic i_in_valid,
    input  wire t_in  i_in_data,
    output logic      o_in_stall,
    // Output channel: one decoded byte or end marker per word.
    output logic      o_out_valid,
    output t_out      o_out_data,
    input  wire logic i_out_stall
);

    t_q_stat q_stat;
    t_cmd    push_cmd;
    t_cmd    head_cmd;
    logic    push;
    logic    pop;

    // The front classifies characters and tracks the partial group.
    b64d_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_in_valid),
        .i_data   (i_in_data),
        .i_q_stat (q_stat),
        .o_stall  (o_in_stall),
        .o_push   (push),
        .o_cmd    (push_cmd)
    );

    // The queue lets either side stall without holding up the other until it fills or runs empty.
    b64d_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_cmd   (head_cmd),
        .o_stat  (q_stat)
    );

    // The back splits each command into its output words.
    b64d_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (head_cmd),
        .i_q_stat (q_stat),
        .o_pop    (pop),
        .o_valid  (o_out_valid),
        .o_data   (o_out_data),
        .i_stall  (i_out_stall)
    );

endmodule

`default_nettype wire
